### design/lbdc_pkg.sv
// package with button codes, register indexes and ladder constants for the keypad controller
package lbdc_pkg;

  typedef enum logic [2:0] {
    KEY_UP,
    KEY_DOWN,
    KEY_MODE,
    KEY_REC,
    KEY_PLAY,
    KEY_SET,
    KEY_IDLE
  } button_t;

  typedef enum logic [2:0] {
    CFG_STABLE_POLLS,
    CFG_VOLUME_STEP,
    CFG_DELAY_STEP,
    CFG_DELAY_LIMIT,
    CFG_IDLE_MARGIN
  } cfg_index_t;

  localparam int unsigned LEVEL_W  = 12;
  localparam int unsigned COUNT_W  = 4;
  localparam int unsigned VOLUME_W = 7;
  localparam int unsigned DSTEP_W  = 9;
  localparam int unsigned DELAY_W  = 10;
  localparam int unsigned MARGIN_W = 10;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 32;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 10;

  localparam logic [12:0] LADDER_TOP_MV = 13'd2880;
  localparam logic [11:0] THRESH_UP     = 12'd2575;
  localparam logic [11:0] THRESH_DOWN   = 12'd2035;
  localparam logic [11:0] THRESH_MODE   = 12'd1570;
  localparam logic [11:0] THRESH_REC    = 12'd1080;
  localparam logic [11:0] THRESH_PLAY   = 12'd560;

  localparam logic [VOLUME_W-1:0] VOLUME_MAX   = 7'd100;
  localparam logic [COUNT_W-1:0]  COUNT_MAX    = 4'd15;
  localparam logic [MODE_W-1:0]   MODE_LAST    = 2'd2;

  localparam logic [COUNT_W-1:0]  STABLE_POLLS_RST = 4'd3;
  localparam logic [VOLUME_W-1:0] VOLUME_STEP_RST  = 7'd5;
  localparam logic [DSTEP_W-1:0]  DELAY_STEP_RST   = 9'd10;
  localparam logic [DELAY_W-1:0]  DELAY_LIMIT_RST  = 10'd300;
  localparam logic [MARGIN_W-1:0] IDLE_MARGIN_RST  = 10'd200;
  localparam logic [VOLUME_W-1:0] VOLUME_RST       = 7'd70;
  localparam logic [MODE_W-1:0]   MODE_RST         = 2'd1;
  localparam logic [DELAY_W-1:0]  DELAY_RST        = 10'd70;

endpackage

### design/ladder_button_debounce_control.sv
// top level: ladder keypad decoder, debounce and volume/mode/mute/delay control
//
//  channel | ports                      | direction | payload
//  --------+----------------------------+-----------+-------------------------------------
//  in      | in_tvalid/in_tready/tdata  | sink      | level_mv [11:0]
//  out     | out_tvalid/out_tready/tdata| source    | one result per poll, see port comment
//  cfg     | cfg_valid/cfg_ready        | sink      | cfg_index selects register, cfg_data
//
// one poll per cycle sustained while out_tready is high: an input register, combinational
// decode and update logic against the control registers, then a result register.
// rst_n is synchronous, active low, and restores the register defaults and control state.
// a stalled result holds in the output register while the input register still takes
// one more poll; cfg_ready is always high.
module ladder_button_debounce_control (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [11:0] level_mv, [15:12] zero
  input  logic [lbdc_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [2:0] button_code, [3] acted, [10:4] volume_level, [11] muted,
  // [13:12] run_mode_out, [23:14] delay_ms, [24] awaiting_release, [31:25] zero
  output logic [lbdc_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [lbdc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [lbdc_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import lbdc_pkg::*;

  // configuration registers
  logic [COUNT_W-1:0]  stable_polls_r;
  logic [VOLUME_W-1:0] volume_step_r;
  logic [DSTEP_W-1:0]  delay_step_r;
  logic [DELAY_W-1:0]  delay_limit_r;
  logic [MARGIN_W-1:0] idle_margin_r;

  // pipeline
  logic                s1_valid_r;
  logic [LEVEL_W-1:0]  s1_level_r;
  logic                out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                out_load;
  logic                s1_fire;

  // control state
  button_t             prev_button_r, prev_button_nxt;
  logic [COUNT_W-1:0]  same_count_r, same_count_nxt;
  logic                release_wait_r, release_wait_nxt;
  logic [VOLUME_W-1:0] volume_r, volume_nxt;
  logic                mute_r, mute_nxt;
  logic [MODE_W-1:0]   mode_r, mode_nxt;
  logic [DELAY_W-1:0]  delay_r, delay_nxt;

  button_t             cur;
  logic                acted;
  logic [12:0]         none_limit;
  logic [COUNT_W-1:0]  count_inc;
  logic [VOLUME_W:0]   vol_sum;
  logic [DELAY_W:0]    dly_sum;
  logic [DELAY_W:0]    dly_diff;
  logic [DELAY_W:0]    dly_raw;

  assign cfg_ready  = 1'b1;
  assign out_load   = !out_valid_r || out_tready;
  assign s1_fire    = s1_valid_r && out_load;
  assign in_tready  = !s1_valid_r || out_load;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_polls_r <= STABLE_POLLS_RST;
      volume_step_r  <= VOLUME_STEP_RST;
      delay_step_r   <= DELAY_STEP_RST;
      delay_limit_r  <= DELAY_LIMIT_RST;
      idle_margin_r  <= IDLE_MARGIN_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_STABLE_POLLS: stable_polls_r <= cfg_data[COUNT_W-1:0];
        CFG_VOLUME_STEP:  volume_step_r  <= cfg_data[VOLUME_W-1:0];
        CFG_DELAY_STEP:   delay_step_r   <= cfg_data[DSTEP_W-1:0];
        CFG_DELAY_LIMIT:  delay_limit_r  <= cfg_data[DELAY_W-1:0];
        CFG_IDLE_MARGIN:  idle_margin_r  <= cfg_data[MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  // ladder decode
  assign none_limit = LADDER_TOP_MV + {3'b000, idle_margin_r};

  always_comb begin
    priority if ({1'b0, s1_level_r} > none_limit) cur = KEY_IDLE;
    else if (s1_level_r >= THRESH_UP)            cur = KEY_UP;
    else if (s1_level_r >= THRESH_DOWN)          cur = KEY_DOWN;
    else if (s1_level_r >= THRESH_MODE)          cur = KEY_MODE;
    else if (s1_level_r >= THRESH_REC)           cur = KEY_REC;
    else if (s1_level_r >= THRESH_PLAY)          cur = KEY_PLAY;
    else                                         cur = KEY_SET;
  end

  assign count_inc = (same_count_r == COUNT_MAX) ? COUNT_MAX : same_count_r + 1'b1;
  assign vol_sum   = {1'b0, volume_r} + {1'b0, volume_step_r};
  assign dly_sum   = {1'b0, delay_r} + {2'b00, delay_step_r};
  assign dly_diff  = (delay_r >= {1'b0, delay_step_r}) ?
                     ({1'b0, delay_r} - {2'b00, delay_step_r}) : '0;

  always_comb begin
    prev_button_nxt  = prev_button_r;
    same_count_nxt   = same_count_r;
    release_wait_nxt = release_wait_r;
    volume_nxt       = volume_r;
    mute_nxt         = mute_r;
    mode_nxt         = mode_r;
    delay_nxt        = delay_r;
    acted            = 1'b0;
    dly_raw          = dly_sum;

    if (release_wait_r) begin
      // release poll is dropped and debounce restarts
      if (cur != prev_button_r) begin
        release_wait_nxt = 1'b0;
        same_count_nxt   = '0;
        prev_button_nxt  = KEY_IDLE;
      end
    end else if (cur == prev_button_r && cur != KEY_IDLE) begin
      same_count_nxt = count_inc;
      if (count_inc >= stable_polls_r) begin
        acted            = 1'b1;
        release_wait_nxt = 1'b1;
        unique case (cur)
          KEY_UP:   volume_nxt = (vol_sum <= {1'b0, VOLUME_MAX}) ?
                                 vol_sum[VOLUME_W-1:0] : VOLUME_MAX;
          KEY_DOWN: volume_nxt = (volume_r >= volume_step_r) ?
                                 volume_r - volume_step_r : '0;
          KEY_MODE: mode_nxt   = (mode_r == MODE_LAST) ? '0 : mode_r + 1'b1;
          KEY_REC, KEY_PLAY: begin
            dly_raw   = (cur == KEY_REC) ? dly_diff : dly_sum;
            delay_nxt = (dly_raw > {1'b0, delay_limit_r}) ?
                        delay_limit_r : dly_raw[DELAY_W-1:0];
          end
          KEY_SET:  mute_nxt = !mute_r;
          default: ;
        endcase
      end
    end else begin
      same_count_nxt  = (cur == KEY_IDLE) ? '0 : COUNT_W'(1);
      prev_button_nxt = cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      prev_button_r  <= KEY_IDLE;
      same_count_r   <= '0;
      release_wait_r <= 1'b0;
      volume_r       <= VOLUME_RST;
      mute_r         <= 1'b0;
      mode_r         <= MODE_RST;
      delay_r        <= DELAY_RST;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (out_load) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_fire) begin
        prev_button_r  <= prev_button_nxt;
        same_count_r   <= same_count_nxt;
        release_wait_r <= release_wait_nxt;
        volume_r       <= volume_nxt;
        mute_r         <= mute_nxt;
        mode_r         <= mode_nxt;
        delay_r        <= delay_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_level_r <= in_tdata[LEVEL_W-1:0];
    end
    if (s1_fire) begin
      out_data_r <= {7'b0000000, release_wait_nxt, delay_nxt, mode_nxt, mute_nxt,
                     volume_nxt, acted, cur};
    end
  end

endmodule

### verif/testbench.sv
// self-checking testbench for the ladder keypad decoder and its volume/mode/mute/delay control
`timescale 1ns / 100ps

module testbench;
  import lbdc_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int NUM_PHASES      = 8;
  localparam int PHASE_ITEMS     = 195;
  localparam int SETTLE_CYCLES   = 6;
  localparam int PRESSURE_PHASE  = 4;
  localparam int PRESSURE_CYCLES = 120;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 3'd7;

  // packed to match out_tdata, msb first
  typedef struct packed {
    logic [6:0]          pad;
    logic                awaiting;
    logic [DELAY_W-1:0]  delay;
    logic [MODE_W-1:0]   mode;
    logic                muted;
    logic [VOLUME_W-1:0] volume;
    logic                acted;
    button_t             button;
  } poll_status_t;

  class keypad_scoreboard;
    logic [COUNT_W-1:0]  stable_polls;
    logic [VOLUME_W-1:0] volume_step;
    logic [DSTEP_W-1:0]  delay_step;
    logic [DELAY_W-1:0]  delay_limit;
    logic [MARGIN_W-1:0] idle_margin;
    button_t             prev_button;
    logic [COUNT_W-1:0]  same_count;
    logic                release_wait;
    logic [VOLUME_W-1:0] volume;
    logic                muted;
    logic [MODE_W-1:0]   mode;
    logic [DELAY_W-1:0]  delay;
    poll_status_t        expected_status[$];
    int                  errors;

    function new();
      stable_polls = STABLE_POLLS_RST;
      volume_step  = VOLUME_STEP_RST;
      delay_step   = DELAY_STEP_RST;
      delay_limit  = DELAY_LIMIT_RST;
      idle_margin  = IDLE_MARGIN_RST;
      prev_button  = KEY_IDLE;
      same_count   = '0;
      release_wait = 1'b0;
      volume       = VOLUME_RST;
      muted        = 1'b0;
      mode         = MODE_RST;
      delay        = DELAY_RST;
      errors       = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_STABLE_POLLS: stable_polls = value[COUNT_W-1:0];
        CFG_VOLUME_STEP:  volume_step  = value[VOLUME_W-1:0];
        CFG_DELAY_STEP:   delay_step   = value[DSTEP_W-1:0];
        CFG_DELAY_LIMIT:  delay_limit  = value[DELAY_W-1:0];
        CFG_IDLE_MARGIN:  idle_margin  = value[MARGIN_W-1:0];
        default: ;
      endcase
    endfunction

    function button_t decode(logic [LEVEL_W-1:0] mv);
      if (int'(mv) > int'(LADDER_TOP_MV) + int'(idle_margin)) return KEY_IDLE;
      if (mv >= THRESH_UP)   return KEY_UP;
      if (mv >= THRESH_DOWN) return KEY_DOWN;
      if (mv >= THRESH_MODE) return KEY_MODE;
      if (mv >= THRESH_REC)  return KEY_REC;
      if (mv >= THRESH_PLAY) return KEY_PLAY;
      return KEY_SET;
    endfunction

    function void note_poll(logic [LEVEL_W-1:0] mv);
      button_t      cur;
      poll_status_t st;
      int           sum;
      cur = decode(mv);
      st = '0;
      if (release_wait) begin
        // the release poll only clears the debounce state
        if (cur != prev_button) begin
          release_wait = 1'b0;
          same_count   = '0;
          prev_button  = KEY_IDLE;
        end
      end else if (cur == prev_button && cur != KEY_IDLE) begin
        if (same_count < COUNT_MAX) same_count++;
        if (same_count >= stable_polls) begin
          case (cur)
            KEY_UP: begin
              sum = int'(volume) + int'(volume_step);
              volume = (sum <= int'(VOLUME_MAX)) ? VOLUME_W'(sum) : VOLUME_MAX;
            end
            KEY_DOWN: volume = (volume >= volume_step) ? volume - volume_step : '0;
            KEY_MODE: mode = (mode == MODE_LAST) ? '0 : mode + 1'b1;
            KEY_REC, KEY_PLAY: begin
              sum = (cur == KEY_REC) ? int'(delay) - int'(delay_step)
                                     : int'(delay) + int'(delay_step);
              if (sum < 0) sum = 0;
              if (sum > int'(delay_limit)) sum = int'(delay_limit);
              delay = DELAY_W'(sum);
            end
            KEY_SET: muted = ~muted;
            default: ;
          endcase
          st.acted     = 1'b1;
          release_wait = 1'b1;
        end
      end else begin
        same_count  = (cur == KEY_IDLE) ? '0 : COUNT_W'(1);
        prev_button = cur;
      end
      st.button   = cur;
      st.volume   = volume;
      st.muted    = muted;
      st.mode     = mode;
      st.delay    = delay;
      st.awaiting = release_wait;
      expected_status.push_back(st);
    endfunction

    task report(string what, int got, int want);
      errors++;
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    task check_result(logic [OUT_TDATA_W-1:0] raw);
      poll_status_t got;
      poll_status_t want;
      got = poll_status_t'(raw);
      if (expected_status.size() == 0) begin
        report("result with no poll pending, tdata", int'(raw), 0);
        return;
      end
      want = expected_status.pop_front();
      if (got.button !== want.button)     report("button_code", got.button, want.button);
      if (got.acted !== want.acted)       report("acted", got.acted, want.acted);
      if (got.volume !== want.volume)     report("volume_level", got.volume, want.volume);
      if (got.muted !== want.muted)       report("muted", got.muted, want.muted);
      if (got.mode !== want.mode)         report("run_mode_out", got.mode, want.mode);
      if (got.delay !== want.delay)       report("delay_ms", got.delay, want.delay);
      if (got.awaiting !== want.awaiting) report("awaiting_release", got.awaiting, want.awaiting);
      if (got.pad !== want.pad)           report("tdata padding", got.pad, want.pad);
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  keypad_scoreboard sb = new();
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cur_phase = -1;
  int hold_left = 0;
  bit pressure_done = 1'b0;

  ladder_button_debounce_control u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off so the block backs up
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (cur_phase == PRESSURE_PHASE && !pressure_done) begin
      out_tready    <= 1'b0;
      hold_left     <= PRESSURE_CYCLES;
      pressure_done <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // handshake inputs are stable from negedge to the next posedge
  always @(negedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  task automatic send_poll(input logic [LEVEL_W-1:0] level);
    bit accepted;
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W-LEVEL_W){1'b0}}, level};
    // hold the request until accepted
    do begin
      @(negedge clk);
      accepted = in_tready;
      @(posedge clk);
    end while (!accepted);
    sb.note_poll(level);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    bit accepted;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do begin
      @(negedge clk);
      accepted = cfg_ready;
      @(posedge clk);
    end while (!accepted);
    sb.write_reg(idx, value);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sb.expected_status.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input int phase);
    int sp, vs, ds, dl, im;
    case (phase)
      0: begin
        sp = 1; vs = 1; ds = 1; dl = 0; im = 0;
      end
      1: begin
        sp = 15; vs = 100; ds = 300; dl = 1023; im = 1000;
      end
      2: begin
        sp = 0;
        vs = $urandom_range(100, 1);
        ds = $urandom_range(300, 1);
        dl = $urandom_range(1023);
        im = $urandom_range(1000);
      end
      3: begin
        // full-width data, upper bits beyond each register must be dropped
        sp = $urandom_range(1023);
        vs = $urandom_range(1023);
        ds = $urandom_range(1023);
        dl = $urandom_range(1023);
        im = $urandom_range(1023);
      end
      default: begin
        sp = $urandom_range(4, 1);
        vs = $urandom_range(100, 1);
        ds = $urandom_range(300, 1);
        dl = $urandom_range(1023);
        im = $urandom_range(1000);
      end
    endcase
    write_reg(CFG_STABLE_POLLS, CFG_DATA_W'(sp));
    write_reg(CFG_VOLUME_STEP, CFG_DATA_W'(vs));
    write_reg(CFG_DELAY_STEP, CFG_DATA_W'(ds));
    write_reg(CFG_DELAY_LIMIT, CFG_DATA_W'(dl));
    write_reg(CFG_IDLE_MARGIN, CFG_DATA_W'(im));
    if (phase == 3) write_reg(CFG_UNUSED, CFG_DATA_W'($urandom_range(1023)));
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [LEVEL_W-1:0] level_for(button_t b);
    int top;
    top = int'(LADDER_TOP_MV) + int'(sb.idle_margin);
    case (b)
      KEY_UP:   return LEVEL_W'($urandom_range((top > 4095) ? 4095 : top, int'(THRESH_UP)));
      KEY_DOWN: return LEVEL_W'($urandom_range(int'(THRESH_UP) - 1, int'(THRESH_DOWN)));
      KEY_MODE: return LEVEL_W'($urandom_range(int'(THRESH_DOWN) - 1, int'(THRESH_MODE)));
      KEY_REC:  return LEVEL_W'($urandom_range(int'(THRESH_MODE) - 1, int'(THRESH_REC)));
      KEY_PLAY: return LEVEL_W'($urandom_range(int'(THRESH_REC) - 1, int'(THRESH_PLAY)));
      KEY_SET:  return LEVEL_W'($urandom_range(int'(THRESH_PLAY) - 1, 0));
      default:  return LEVEL_W'($urandom_range(4095, top + 1));
    endcase
  endfunction

  initial begin
    logic [LEVEL_W-1:0] directed[$];
    button_t            b;
    button_t            rel;
    int                 hold;
    int                 sent;
    int                 sp;

    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // band edges, the none boundary at top plus margin, then debounced presses
    directed = '{12'd0, 12'd4095, 12'd3080, 12'd3081, 12'd2575, 12'd2574,
                 12'd2035, 12'd2034, 12'd1570, 12'd1569, 12'd1080, 12'd1079,
                 12'd560, 12'd559,
                 12'd2575, 12'd2575, 12'd2575, 12'd2575, 12'd3500,
                 12'd2034, 12'd2034, 12'd2034, 12'd0, 12'd0, 12'd0};
    foreach (directed[i]) send_poll(directed[i]);
    wait_idle();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct <= 77; recv_stall_pct <= 0;  end
        2: begin send_idle_pct <= 0;  recv_stall_pct <= 77; end
        default: begin send_idle_pct <= 29; recv_stall_pct <= 29; end
      endcase
      configure(phase);
      cur_phase <= phase;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(99) < 80) begin
          // press held for a random length, then a release to another band
          b  = button_t'($urandom_range(5));
          sp = int'(sb.stable_polls);
          if ($urandom_range(1)) hold = sp + $urandom_range(3);
          else hold = $urandom_range(sp + 1, 1);
          if (hold < 1) hold = 1;
          repeat (hold) begin
            send_poll(level_for(b));
            sent++;
          end
          do rel = button_t'($urandom_range(6)); while (rel == b);
          send_poll(level_for(rel));
          sent++;
        end else begin
          send_poll(LEVEL_W'($urandom_range(4095)));
          sent++;
        end
      end
      wait_idle();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

### sim.f
design/lbdc_pkg.sv
design/ladder_button_debounce_control.sv
verif/testbench.sv
